// ----- rtl/core/rac_pkg.sv -----
package rac_pkg;

    typedef enum logic [1:0] {
        ACT_MOV = 2'd0,
        ACT_ADD = 2'd1,
        ACT_SUB = 2'd2,
        ACT_CMP = 2'd3
    } t_action;

    localparam int IDX_W  = 4;
    localparam int PART_W = 2;
    localparam int WORD_W = 16;

    localparam logic [PART_W-1:0] PART_WHOLE = 2'd0;
    localparam logic [PART_W-1:0] PART_LOW   = 2'd1;
    localparam logic [PART_W-1:0] PART_HIGH  = 2'd2;

    // only the first registers have addressable byte halves
    localparam logic [IDX_W-1:0] NUM_BYTE_REGS = 4'd4;

    localparam int FLAG_CF = 0;
    localparam int FLAG_PF = 2;
    localparam int FLAG_ZF = 6;
    localparam int FLAG_SF = 7;
    localparam int FLAG_OF = 11;

    localparam logic [WORD_W-1:0] FLAG_MASK  = 16'h08C5;
    localparam logic [WORD_W-1:0] MASK_BYTE  = 16'h00FF;
    localparam logic [WORD_W-1:0] MASK_WORD  = 16'hFFFF;

    typedef struct packed {
        t_action            action;
        logic [IDX_W-1:0]   dest_index;
        logic [PART_W-1:0]  dest_part;
        logic               src_is_register;
        logic [IDX_W-1:0]   src_index;
        logic [PART_W-1:0]  src_part;
        logic [WORD_W-1:0]  immediate_value;
    } t_instr;

    typedef struct packed {
        logic [WORD_W-1:0]  old_dest_value;
        logic [WORD_W-1:0]  new_dest_value;
        logic [WORD_W-1:0]  flags_value;
        logic               wr_en;
    } t_alu_res;

endpackage

// ----- rtl/core/rac_alu.sv -----
module rac_alu import rac_pkg::*; (
    input  t_instr             i_instr,
    input  logic               i_dest_ok,
    input  logic [WORD_W-1:0]  i_dest_word,
    input  logic [WORD_W-1:0]  i_src_word,
    input  logic [WORD_W-1:0]  i_flags,
    output t_alu_res           o_res
);

    function automatic logic [PART_W-1:0] norm_part(
        input logic [IDX_W-1:0]  idx,
        input logic [PART_W-1:0] part
    );
        if (idx < NUM_BYTE_REGS && (part == PART_LOW || part == PART_HIGH)) begin
            return part;
        end
        return PART_WHOLE;
    endfunction

    function automatic logic [WORD_W-1:0] pick_part(
        input logic [WORD_W-1:0] whole,
        input logic [PART_W-1:0] part
    );
        case (part)
            PART_LOW:  return {8'h00, whole[7:0]};
            PART_HIGH: return {8'h00, whole[15:8]};
            default:   return whole;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] merge_part(
        input logic [WORD_W-1:0] whole,
        input logic [WORD_W-1:0] val,
        input logic [PART_W-1:0] part
    );
        case (part)
            PART_LOW:  return {whole[15:8], val[7:0]};
            PART_HIGH: return {val[7:0], whole[7:0]};
            default:   return val;
        endcase
    endfunction

    logic [PART_W-1:0] w_dpart;
    logic [PART_W-1:0] w_spart;
    logic              w_is_byte;
    logic [WORD_W-1:0] w_mask;
    logic [WORD_W-1:0] w_src;
    logic [WORD_W-1:0] w_a;
    logic [WORD_W-1:0] w_b;
    logic [WORD_W:0]   w_wide;
    logic [WORD_W-1:0] w_res;
    logic              w_sa;
    logic              w_sb;
    logic              w_sr;
    logic              w_cf;
    logic              w_of;
    logic [WORD_W-1:0] w_newv;
    logic [WORD_W-1:0] w_flags;

    always_comb begin
        w_dpart   = norm_part(i_instr.dest_index, i_instr.dest_part);
        w_spart   = norm_part(i_instr.src_index, i_instr.src_part);
        w_is_byte = (w_dpart != PART_WHOLE);
        w_mask    = w_is_byte ? MASK_BYTE : MASK_WORD;
        w_src     = i_instr.src_is_register ? pick_part(i_src_word, w_spart)
                                            : i_instr.immediate_value;
        w_a       = pick_part(i_dest_word, w_dpart);
        w_b       = w_src & w_mask;

        if (i_instr.action == ACT_ADD) begin
            w_wide = {1'b0, w_a} + {1'b0, w_b};
        end else begin
            w_wide = {1'b0, w_a} - {1'b0, w_b};
        end
        w_res = w_wide[WORD_W-1:0] & w_mask;

        // carry or borrow out of the operand width
        w_cf = w_is_byte ? w_wide[8] : w_wide[WORD_W];
        w_sa = w_is_byte ? w_a[7] : w_a[WORD_W-1];
        w_sb = w_is_byte ? w_b[7] : w_b[WORD_W-1];
        w_sr = w_is_byte ? w_res[7] : w_res[WORD_W-1];
        if (i_instr.action == ACT_ADD) begin
            w_of = (w_sa == w_sb) && (w_sa != w_sr);
        end else begin
            w_of = (w_sa != w_sb) && (w_sa != w_sr);
        end

        w_flags = i_flags;
        w_newv  = i_dest_word;
        case (i_instr.action)
            ACT_MOV: begin
                w_newv = merge_part(i_dest_word, w_src, w_dpart);
            end
            ACT_ADD, ACT_SUB, ACT_CMP: begin
                w_flags[FLAG_OF] = w_of;
                w_flags[FLAG_CF] = w_cf;
                w_flags[FLAG_ZF] = (w_res == '0);
                w_flags[FLAG_SF] = w_sr;
                w_flags[FLAG_PF] = ~^w_res[7:0];
                if (i_instr.action != ACT_CMP) begin
                    w_newv = merge_part(i_dest_word, w_res, w_dpart);
                end
            end
            default: begin
                w_newv = i_dest_word;
            end
        endcase

        o_res.old_dest_value = i_dest_word;
        o_res.new_dest_value = i_dest_ok ? w_newv : '0;
        o_res.flags_value    = w_flags;
        o_res.wr_en          = i_dest_ok;
    end

endmodule

// ----- rtl/core/register_alu_mov_add_sub_cmp_unit.sv -----
// channel   dir  tdata (low bit up)                                          tuser
// s         in   action[1:0] dest_index[5:2] dest_part[7:6] src_index[11:8]  src_is_register
//                src_part[13:12] immediate_value[29:14] zero[31:30]
// m         out  old_dest_value[15:0] new_dest_value[31:16] flags_value[47:32] -
//
// one instruction per cycle unless m stalls; s -> execute register -> output register -> m
// the register file is a two-read one-write memory with registered reads;
// the last write is forwarded to the execute stage for back-to-back dependences
// reset clears the per-entry valid bits, so unwritten registers read as zero at once
// a stalled m side holds the execute stage, which then stops new transfers on s
module register_alu_mov_add_sub_cmp_unit import rac_pkg::*; #(
    parameter int NUM_REGISTERS = 13
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // action, dest_index, dest_part, src_index, src_part, immediate_value, zero pad
    input  logic [31:0] i_s_tdata,
    // src_is_register
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // old_dest_value, new_dest_value, flags_value
    output logic [47:0] o_m_tdata
);

    localparam int AddrW = $clog2(NUM_REGISTERS);
    localparam logic [IDX_W:0] NumRegs = (IDX_W+1)'(NUM_REGISTERS);

    logic [WORD_W-1:0]        r_mem [NUM_REGISTERS];
    logic [WORD_W-1:0]        r_rd_dest;
    logic [WORD_W-1:0]        r_rd_src;
    logic [NUM_REGISTERS-1:0] r_reg_vld;
    logic                     r_last_vld;
    logic [IDX_W-1:0]         r_last_idx;
    logic [WORD_W-1:0]        r_last_val;

    t_instr                   w_in;
    t_instr                   r_s1;
    logic                     r_s1_valid;
    logic [WORD_W-1:0]        r_flags;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic [47:0]              r_out_data;

    logic                     w_s_acc;
    logic                     w_s1_adv;
    logic                     w_wr;
    logic                     w_dest_ok;
    logic                     w_src_ok;
    logic [WORD_W-1:0]        w_dest_word;
    logic [WORD_W-1:0]        w_src_word;
    t_alu_res                 w_res;

    always_comb begin
        w_in.action          = t_action'(i_s_tdata[1:0]);
        w_in.dest_index      = i_s_tdata[5:2];
        w_in.dest_part       = i_s_tdata[7:6];
        w_in.src_is_register = i_s_tuser;
        w_in.src_index       = i_s_tdata[11:8];
        w_in.src_part        = i_s_tdata[13:12];
        w_in.immediate_value = i_s_tdata[29:14];
    end

    assign w_s1_adv   = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || w_s1_adv;
    assign w_s_acc    = i_s_tvalid && o_s_tready;

    assign w_dest_ok = ({1'b0, r_s1.dest_index} < NumRegs);
    assign w_src_ok  = ({1'b0, r_s1.src_index} < NumRegs);
    assign w_wr      = w_s1_adv && w_res.wr_en;

    // operand fetch: forward the last write, else memory data if the entry was written
    always_comb begin
        w_dest_word = '0;
        if (w_dest_ok) begin
            if (r_last_vld && r_last_idx == r_s1.dest_index) begin
                w_dest_word = r_last_val;
            end else if (r_reg_vld[r_s1.dest_index[AddrW-1:0]]) begin
                w_dest_word = r_rd_dest;
            end
        end
        w_src_word = '0;
        if (w_src_ok) begin
            if (r_last_vld && r_last_idx == r_s1.src_index) begin
                w_src_word = r_last_val;
            end else if (r_reg_vld[r_s1.src_index[AddrW-1:0]]) begin
                w_src_word = r_rd_src;
            end
        end
    end

    rac_alu u_alu (
        .i_instr     (r_s1),
        .i_dest_ok   (w_dest_ok),
        .i_dest_word (w_dest_word),
        .i_src_word  (w_src_word),
        .i_flags     (r_flags),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_rd_dest <= r_mem[w_in.dest_index[AddrW-1:0]];
            r_rd_src  <= r_mem[w_in.src_index[AddrW-1:0]];
        end
        if (w_wr) begin
            r_mem[r_s1.dest_index[AddrW-1:0]] <= w_res.new_dest_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_s1 <= w_in;
        end
        if (w_wr) begin
            r_last_idx <= r_s1.dest_index;
            r_last_val <= w_res.new_dest_value;
        end
        if (w_s1_adv) begin
            r_out_data <= {w_res.flags_value, w_res.new_dest_value, w_res.old_dest_value};
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_s1_adv) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
            r_reg_vld   <= '0;
            r_last_vld  <= 1'b0;
        end else begin
            if (w_s_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            r_out_valid <= n_out_valid;
            if (w_s1_adv) begin
                r_flags <= w_res.flags_value;
            end
            if (w_wr) begin
                r_reg_vld[r_s1.dest_index[AddrW-1:0]] <= 1'b1;
                r_last_vld <= 1'b1;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_adv |=> o_m_tvalid)
        else $error("executed instruction did not reach the output register");

    a_held_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_adv) |-> !o_s_tready)
        else $error("input taken while execute stage is held");

    a_write_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> r_reg_vld[$past(r_s1.dest_index[AddrW-1:0])])
        else $error("written register not marked valid");

    a_flags_only_defined: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flags & ~FLAG_MASK) == '0)
        else $error("undefined flag bit set");

    a_mov_keeps_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && r_s1.action == ACT_MOV) |=> r_flags == $past(r_flags))
        else $error("mov changed the flags");

endmodule
